// ----- sv/orb_pkg.sv -----
// Types, constants and codes shared by the ordered record table modules.
package orb_pkg;

  localparam int TABLE_ENTRIES  = 16;
  localparam int NAME_BYTES     = 30;
  localparam int NAME_MAX_BYTES = 32;
  localparam int NAME_W         = 8 * NAME_MAX_BYTES;
  localparam int CODE_W         = 32;
  localparam int POS_W          = 5;
  localparam int IDX_W          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W          = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_REMOVE = 2'd3
  } orb_action_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } orb_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SHIFT
  } orb_state_e;

  typedef struct packed {
    orb_action_e        action;
    logic signed [31:0] entry_code;
    logic [63:0]        name_word0;
    logic [63:0]        name_word1;
    logic [63:0]        name_word2;
    logic [63:0]        name_word3;
  } orb_in_t;

  typedef struct packed {
    orb_status_e        status;
    logic [POS_W-1:0]   position;
    logic signed [31:0] record_code;
    logic [63:0]        out_name_word0;
    logic [63:0]        out_name_word1;
    logic [63:0]        out_name_word2;
    logic [63:0]        out_name_word3;
    logic               last;
  } orb_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [NAME_W-1:0] name;
  } orb_rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    orb_rec_t         wdata;
    logic [IDX_W-1:0] raddr;
  } orb_ram_req_t;

  typedef struct packed {
    orb_state_e       state;
    logic [CNT_W-1:0] cnt;
  } orb_stat_t;

endpackage

// ----- sv/orb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module orb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/orb_canon.sv -----
// Name canonicalizer: zero every byte from the first zero byte or the length limit on.
module orb_canon (
  input  logic [orb_pkg::NAME_W-1:0] raw_i,
  output logic [orb_pkg::NAME_W-1:0] key_o
);

  always_comb begin
    logic ended;
    ended = 1'b0;
    key_o = '0;
    for (int b = 0; b < orb_pkg::NAME_MAX_BYTES; b++) begin
      if (b >= orb_pkg::NAME_BYTES || raw_i[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        key_o[8*b +: 8] = raw_i[8*b +: 8];
      end
    end
  end

endmodule

// ----- sv/orb_seq.sv -----
// Sequencer: walks the record RAM one entry a cycle through a shared name comparator.
module orb_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  orb_pkg::orb_in_t           item_i,
  input  logic [orb_pkg::NAME_W-1:0] key_i,
  input  orb_pkg::orb_rec_t          rdata_i,
  output logic                       busy_o,
  output orb_pkg::orb_ram_req_t      ram_o,
  output logic                       res_valid_o,
  output orb_pkg::orb_out_t          res_o,
  output orb_pkg::orb_stat_t         stat_o
);

  localparam int XW = orb_pkg::CNT_W + 1;

  orb_pkg::orb_state_e         state_q, state_d;
  logic [orb_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [orb_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  orb_pkg::orb_action_e        act_q, act_d;
  logic [orb_pkg::NAME_W-1:0]  key_q, key_d;
  logic                        rv_q, rv_d;
  orb_pkg::orb_out_t           res_q, res_d;

  logic          accept;
  logic          match;
  logic          full;
  logic [XW-1:0] idx1, idx2, cnt_x, cnt1;

  assign accept = start_i && (state_q == orb_pkg::ST_IDLE);
  assign match  = (rdata_i.name == key_q);
  assign full   = (cnt_q == orb_pkg::CNT_W'(orb_pkg::TABLE_ENTRIES));
  assign idx1   = XW'(idx_q) + XW'(1);
  assign idx2   = XW'(idx_q) + XW'(2);
  assign cnt_x  = XW'(cnt_q);
  assign cnt1   = XW'(cnt_q) + XW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orb_pkg::ST_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    act_q <= act_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    act_d         = act_q;
    key_d         = key_q;
    rv_d          = 1'b0;
    res_d         = res_q;
    ram_o.we      = 1'b0;
    ram_o.waddr   = orb_pkg::IDX_W'(cnt_q);
    ram_o.wdata   = {item_i.entry_code, key_i};
    ram_o.raddr   = '0;

    case (state_q)
      orb_pkg::ST_IDLE: begin
        if (accept) begin
          rv_d  = 1'b1;
          res_d = '0;
          res_d.last = 1'b1;
          if (item_i.action == orb_pkg::ACT_APPEND) begin
            if (full) begin
              res_d.status = orb_pkg::STATUS_FULL;
            end else begin
              ram_o.we             = 1'b1;
              cnt_d                = cnt_q + orb_pkg::CNT_W'(1);
              res_d.status         = orb_pkg::STATUS_OK;
              res_d.position       = orb_pkg::POS_W'(cnt1);
              res_d.record_code    = item_i.entry_code;
              res_d.out_name_word0 = key_i[63:0];
              res_d.out_name_word1 = key_i[127:64];
              res_d.out_name_word2 = key_i[191:128];
              res_d.out_name_word3 = key_i[255:192];
            end
          end else if (cnt_q == '0) begin
            res_d.status = orb_pkg::STATUS_EMPTY;
          end else begin
            rv_d    = 1'b0;
            act_d   = item_i.action;
            key_d   = key_i;
            idx_d   = '0;
            state_d = orb_pkg::ST_RUN;
          end
        end
      end
      orb_pkg::ST_RUN: begin
        ram_o.raddr = orb_pkg::IDX_W'(idx1);
        res_d                = '0;
        res_d.status         = orb_pkg::STATUS_OK;
        res_d.position       = orb_pkg::POS_W'(idx1);
        res_d.record_code    = rdata_i.code;
        res_d.out_name_word0 = rdata_i.name[63:0];
        res_d.out_name_word1 = rdata_i.name[127:64];
        res_d.out_name_word2 = rdata_i.name[191:128];
        res_d.out_name_word3 = rdata_i.name[255:192];
        res_d.last           = 1'b1;
        if (act_q == orb_pkg::ACT_READ) begin
          rv_d       = 1'b1;
          res_d.last = (idx1 == cnt_x);
          if (idx1 == cnt_x) begin
            state_d = orb_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + orb_pkg::IDX_W'(1);
          end
        end else if (match) begin
          rv_d = 1'b1;
          if (act_q == orb_pkg::ACT_REMOVE && idx1 != cnt_x) begin
            state_d = orb_pkg::ST_SHIFT;
          end else begin
            state_d = orb_pkg::ST_IDLE;
            if (act_q == orb_pkg::ACT_REMOVE) begin
              cnt_d = cnt_q - orb_pkg::CNT_W'(1);
            end
          end
        end else if (idx1 == cnt_x) begin
          rv_d         = 1'b1;
          res_d        = '0;
          res_d.status = orb_pkg::STATUS_NOTFOUND;
          res_d.last   = 1'b1;
          state_d      = orb_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + orb_pkg::IDX_W'(1);
        end
      end
      orb_pkg::ST_SHIFT: begin
        ram_o.raddr = orb_pkg::IDX_W'(idx2);
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = rdata_i;
        if (idx2 < cnt_x) begin
          idx_d = idx_q + orb_pkg::IDX_W'(1);
        end else begin
          cnt_d   = cnt_q - orb_pkg::CNT_W'(1);
          state_d = orb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = orb_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != orb_pkg::ST_IDLE);
  assign res_valid_o  = rv_q;
  assign res_o        = res_q;
  assign stat_o.state = state_q;
  assign stat_o.cnt   = cnt_q;

endmodule

// ----- sv/ordered_record_table.sv -----
// Top level of the ordered record table: canonicalizer, record RAM and sequencer.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+----------------------
//   command   | start_i high while busy_o low | item_i  (orb_in_t)
//   result    | res_valid_o, one cycle each   | res_o   (orb_out_t)
//
// Append, a full table and an empty table answer in the cycle after the item, busy_o
// stays low. Read out holds busy_o to give one result per entry from the RAM port.
// Search holds busy_o while it walks the entries up to the match position p (or n);
// remove then moves each later entry down one place, one RAM read and one write each.
// Reset empties the table at once; RAM contents are not cleared.
// Results cannot be stalled by the receiver.
module ordered_record_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  orb_pkg::orb_in_t  item_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output orb_pkg::orb_out_t res_o
);

  logic [orb_pkg::NAME_W-1:0] key;
  orb_pkg::orb_rec_t          rdata;
  orb_pkg::orb_ram_req_t      ram_req;
  orb_pkg::orb_stat_t         stat;

  orb_canon u_canon (
    .raw_i ({item_i.name_word3, item_i.name_word2, item_i.name_word1, item_i.name_word0}),
    .key_o (key)
  );

  orb_ram #(
    .WIDTH ($bits(orb_pkg::orb_rec_t)),
    .DEPTH (orb_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  orb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .key_i       (key),
    .rdata_i     (rdata),
    .busy_o      (busy_o),
    .ram_o       (ram_req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .stat_o      (stat)
  );

  a_append_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.action == orb_pkg::ACT_APPEND)
      |=> (res_valid_o && res_o.last))
    else $error("append item gave no single result");

  a_stream_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> res_valid_o)
    else $error("read out stream broke before its last item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt <= orb_pkg::CNT_W'(orb_pkg::TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != orb_pkg::STATUS_OK)
      |-> (res_o.last && res_o.position == '0))
    else $error("error result not final or has a position");

endmodule
